FILE: hdl/ogglpd_pkg.sv
// Shared types and constants for the Ogg last page duration unit.
package ogglpd_pkg;

   // Page header bytes held in the window, offsets 0 to 25; offset 26 is the live byte.
   localparam int CellCount = 26;

   localparam int GranuleFirst = 6;
   localparam int GranuleBytes = 8;

   localparam logic [7:0] CapO = 8'h4F;
   localparam logic [7:0] CapG = 8'h67;
   localparam logic [7:0] CapS = 8'h53;

   // 48000 * 3600 * 6 samples, six hours
   localparam logic [63:0] MaxGranule = 64'd1036800000;

   // granule / 48000 == (granule >> 7) / 375; the latter by reciprocal multiply
   localparam int ScaleShift  = 7;
   localparam int ScaledWidth = 23;
   localparam int RecipWidth  = 24;
   localparam logic [RecipWidth-1:0] Recip375 = 24'd11453247;
   localparam int RecipShift  = 32;
   localparam int SecWidth    = 15;

   typedef logic [7:0] octet_type;
   typedef octet_type [CellCount-1:0] window_type;

   typedef struct packed {
      logic                   ok;
      logic [ScaledWidth-1:0] scaled;
   } snap_type;

endpackage

FILE: hdl/ogglpd_if.sv
// Valid/ready channel interfaces for the byte input and the duration result.
interface ogglpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ogglpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [14:0] duration_seconds;

   modport source (output valid, output duration_seconds, input ready);
   modport sink (input valid, input duration_seconds, output ready);
endinterface

FILE: hdl/ogglpd_byte_cell.sv
// One byte cell of the header window; takes its d_in byte on every beat.
module ogglpd_byte_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 shift,
   input  logic                 clear,
   input  ogglpd_pkg::octet_type d_in,
   output ogglpd_pkg::octet_type q
);

   ogglpd_pkg::octet_type q_ff;

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         q_ff <= '0;
      end else if (shift) begin
         q_ff <= d_in;
      end
   end

   assign q = q_ff;

endmodule

FILE: hdl/ogglpd_page_match.sv
// Capture pattern match on the window and the committed granule register.
module ogglpd_page_match (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic                   last,
   input  ogglpd_pkg::window_type window,
   output ogglpd_pkg::snap_type   snap
);

   logic [63:0] granule_ff;
   logic [63:0] granule_in;
   logic        valid_ff;
   logic        valid_in;
   logic [63:0] window_granule;
   logic        hit;

   // window[0] is the oldest byte: the page start when the live byte is offset 26
   assign hit = (window[0] == ogglpd_pkg::CapO) && (window[1] == ogglpd_pkg::CapG)
             && (window[2] == ogglpd_pkg::CapG) && (window[3] == ogglpd_pkg::CapS);

   always_comb begin
      for (int i = 0; i < ogglpd_pkg::GranuleBytes; i++) begin
         window_granule[i*8 +: 8] = window[ogglpd_pkg::GranuleFirst + i];
      end
   end

   assign granule_in = hit ? window_granule : granule_ff;
   assign valid_in   = hit || valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         granule_ff <= '0;
         valid_ff   <= 1'b0;
      end else if (accept) begin
         // drop everything at the stream end
         granule_ff <= last ? '0 : granule_in;
         valid_ff   <= last ? 1'b0 : valid_in;
      end
   end

   assign snap.ok = valid_in && (granule_in != '0) && (granule_in <= ogglpd_pkg::MaxGranule);
   assign snap.scaled = granule_in[ogglpd_pkg::ScaleShift +: ogglpd_pkg::ScaledWidth];

endmodule

FILE: hdl/ogglpd_sec_div.sv
// Two-stage seconds conversion: hold the scaled granule, then reciprocal multiply.
module ogglpd_sec_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                load,
   input  ogglpd_pkg::snap_type                snap,
   output logic                                load_ready,
   output logic                                out_valid,
   input  logic                                out_ready,
   output logic [ogglpd_pkg::SecWidth-1:0]     out_seconds
);

   localparam int ProdWidth = ogglpd_pkg::ScaledWidth + ogglpd_pkg::RecipWidth;

   logic                                 s1_valid_ff;
   logic                                 s1_valid_in;
   ogglpd_pkg::snap_type                 s1_snap_ff;
   logic                                 out_valid_ff;
   logic                                 out_valid_in;
   logic [ogglpd_pkg::SecWidth-1:0]      out_sec_ff;
   logic [ogglpd_pkg::SecWidth-1:0]      out_sec_in;
   logic [ProdWidth-1:0]                 product;
   logic                                 out_free;
   logic                                 s1_free;

   assign out_free = !out_valid_ff || out_ready;
   assign s1_free  = !s1_valid_ff || out_free;

   assign s1_valid_in  = s1_free ? load : s1_valid_ff;
   assign out_valid_in = out_free ? s1_valid_ff : out_valid_ff;

   assign product = ProdWidth'(s1_snap_ff.scaled) * ProdWidth'(ogglpd_pkg::Recip375);
   assign out_sec_in = s1_snap_ff.ok
                     ? product[ogglpd_pkg::RecipShift +: ogglpd_pkg::SecWidth] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_snap_ff <= snap;
      end
      if (out_free && s1_valid_ff) begin
         out_sec_ff <= out_sec_in;
      end
   end

   assign load_ready  = s1_free;
   assign out_valid   = out_valid_ff;
   assign out_seconds = out_sec_ff;

endmodule

FILE: hdl/ogg_last_page_duration_unit.sv
// Top level of the Ogg last page duration unit.
//
//   channel  dir  payload                              beat
//   req      in   data_byte[7:0], last_byte            valid & ready
//   rsp      out  duration_seconds[14:0]               valid & ready
//
// One byte per cycle; ready falls only when both stages are full and rsp stalls.
// After its last byte, a result is first registered with the match and granule
// scaling, then registered again after the reciprocal multiply by 1/375.
// Synchronous reset clears the 26-byte window chain and the committed granule.
// The last byte clears them again, so the next stream may follow at once.
module ogg_last_page_duration_unit (
   input logic          clock,
   input logic          reset,
   ogglpd_req_if.sink   req_if,
   ogglpd_rsp_if.source rsp_if
);

   ogglpd_pkg::window_type window;
   ogglpd_pkg::snap_type   snap;
   logic                   accept;
   logic                   load_ready;
   logic                   flush;

   assign accept = req_if.valid && load_ready;
   assign flush  = accept && req_if.last_byte;
   assign req_if.ready = load_ready;

   // newest byte enters at the high end and moves toward offset 0
   for (genvar i = 0; i < ogglpd_pkg::CellCount; i++) begin : g_cell
      ogglpd_pkg::octet_type d_in;
      if (i == ogglpd_pkg::CellCount - 1) begin : g_head
         assign d_in = req_if.data_byte;
      end else begin : g_body
         assign d_in = window[i+1];
      end
      ogglpd_byte_cell u_cell (
         .clock (clock),
         .reset (reset),
         .shift (accept),
         .clear (flush),
         .d_in  (d_in),
         .q     (window[i])
      );
   end

   ogglpd_page_match u_match (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .last   (req_if.last_byte),
      .window (window),
      .snap   (snap)
   );

   ogglpd_sec_div u_div (
      .clock       (clock),
      .reset       (reset),
      .load        (flush),
      .snap        (snap),
      .load_ready  (load_ready),
      .out_valid   (rsp_if.valid),
      .out_ready   (rsp_if.ready),
      .out_seconds (rsp_if.duration_seconds)
   );

endmodule
